// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on the aclk / aresetn domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("assertion failed");

`endif

// File: design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, character codes and helper functions of the sentence parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_pkg;

    // Frame buffer depth; one byte less than this is kept per frame.
    localparam int FRAME_BYTES = 96;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(FRAME_BYTES - 1);
    localparam int PREFIX_LEN  = 5;

    // Character codes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Result classification
    typedef enum logic [2:0] {
        KIND_IGNORED   = 3'd0,
        KIND_CKSUM_ERR = 3'd1,
        KIND_SUGGEST   = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_COUNT     = 3'd4
    } frame_kind_t;

    // Per-byte step command shared by the frame tracker and field parser
    typedef struct packed {
        logic             clear;
        logic             advance;
        logic [7:0]       ch;
        logic [CNT_W-1:0] idx;
    } step_t;

    // Frame tracker status
    typedef struct packed {
        logic             empty;
        logic             overfull;
        logic             star_seen;
        logic             cksum_ok;
        logic             long_enough;
        logic [CNT_W-1:0] idx;
    } frm_status_t;

    // Field parser status
    typedef struct packed {
        logic        sug_match;
        logic [1:0]  fields_matched;
        logic [7:0]  count;
        logic [15:0] temp;
        logic [15:0] dist_val;
    } parse_status_t;

    // Suggestion prefix "$SUG,"
    function automatic logic [7:0] sug_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h53;
            3'd2:    c = 8'h55;
            3'd3:    c = 8'h47;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    // Report prefix: dollar, report tag of three letters, comma
    function automatic logic [7:0] rep_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h53;
            3'd3:    c = 8'h50;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Hex digit decode: bit 4 set when the character is a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(c)) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// File: design/csp_frame_track.sv
// ----------------------------------------------------------------------------
// csp_frame_track
// Byte count, running XOR and star trailer tracking for one frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_frame_track
    import csp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  step_t       step,
    output frm_status_t status
);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic [7:0]       xor_before_star_reg, xor_before_star_next;
    logic             star_seen_reg, star_seen_next;
    logic [1:0]       chars_after_star_reg, chars_after_star_next;
    logic [7:0]       trailer_value_reg, trailer_value_next;
    logic             trailer_bad_reg, trailer_bad_next;
    logic [4:0]       nib;

    assign nib = hex_decode(step.ch);

    // Update the frame bookkeeping for one byte
    always_comb begin
        byte_count_next       = byte_count_reg;
        running_xor_next      = running_xor_reg;
        xor_before_star_next  = xor_before_star_reg;
        star_seen_next        = star_seen_reg;
        chars_after_star_next = chars_after_star_reg;
        trailer_value_next    = trailer_value_reg;
        trailer_bad_next      = trailer_bad_reg;
        if (step.clear) begin
            byte_count_next       = '0;
            running_xor_next      = 8'd0;
            xor_before_star_next  = 8'd0;
            star_seen_next        = 1'b0;
            chars_after_star_next = 2'd0;
            trailer_value_next    = 8'd0;
            trailer_bad_next      = 1'b0;
        end else if (step.advance) begin
            if (step.ch == CH_STAR) begin
                xor_before_star_next  = running_xor_reg;
                star_seen_next        = 1'b1;
                chars_after_star_next = 2'd0;
                trailer_value_next    = 8'd0;
                trailer_bad_next      = 1'b0;
            end else if (star_seen_reg) begin
                if (chars_after_star_reg != 2'd3) begin
                    chars_after_star_next = chars_after_star_reg + 2'd1;
                end
                if (!nib[4]) begin
                    trailer_bad_next = 1'b1;
                end else begin
                    trailer_value_next = {trailer_value_reg[3:0], nib[3:0]};
                end
            end
            // Leading dollar stays out of the checksum
            if (!(step.idx == '0 && step.ch == CH_DOLLAR)) begin
                running_xor_next = running_xor_reg ^ step.ch;
            end
            byte_count_next = step.idx + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg       <= '0;
            running_xor_reg      <= 8'd0;
            xor_before_star_reg  <= 8'd0;
            star_seen_reg        <= 1'b0;
            chars_after_star_reg <= 2'd0;
            trailer_value_reg    <= 8'd0;
            trailer_bad_reg      <= 1'b0;
        end else begin
            byte_count_reg       <= byte_count_next;
            running_xor_reg      <= running_xor_next;
            xor_before_star_reg  <= xor_before_star_next;
            star_seen_reg        <= star_seen_next;
            chars_after_star_reg <= chars_after_star_next;
            trailer_value_reg    <= trailer_value_next;
            trailer_bad_reg      <= trailer_bad_next;
        end
    end

    // Report frame state
    assign status.empty       = (byte_count_reg == '0);
    assign status.overfull    = (byte_count_reg >= FRAME_LIMIT);
    assign status.star_seen   = star_seen_reg;
    assign status.cksum_ok    = !star_seen_reg ||
                                (chars_after_star_reg == 2'd2 && !trailer_bad_reg &&
                                 trailer_value_reg == xor_before_star_reg);
    assign status.long_enough = (byte_count_reg >= CNT_W'(PREFIX_LEN));
    assign status.idx         = byte_count_reg;

endmodule

// File: design/csp_field_parse.sv
// ----------------------------------------------------------------------------
// csp_field_parse
// Prefix match and decimal field parser for count, temperature and distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_field_parse
    import csp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  step_t         step,
    output parse_status_t status
);

    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_FIRST  = 5'b00100,
        PH_MORE   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  field_reg, field_next;
    logic [1:0]  flags_reg, flags_next;
    logic        sign_reg, sign_next;
    logic [1:0]  matched_reg, matched_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] dist_reg, dist_next;
    logic        take_first;
    logic        do_digit;
    logic        first_digit;
    logic [15:0] old_val;
    logic [15:0] base_val;
    logic [15:0] new_val;
    logic [15:0] digit_val;

    assign digit_val = {12'd0, step.ch[3:0]};

    // Advance the parse state for one byte
    always_comb begin
        phase_next   = phase_reg;
        field_next   = field_reg;
        flags_next   = flags_reg;
        sign_next    = sign_reg;
        matched_next = matched_reg;
        take_first   = 1'b0;
        do_digit     = 1'b0;
        first_digit  = 1'b0;
        if (step.clear) begin
            phase_next   = PH_PREFIX;
            field_next   = 2'd0;
            flags_next   = 2'b11;
            sign_next    = 1'b0;
            matched_next = 2'd0;
        end else if (step.advance) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (step.idx < CNT_W'(PREFIX_LEN)) begin
                        flags_next = flags_reg &
                                     {step.ch == rep_char(step.idx[2:0]),
                                      step.ch == sug_char(step.idx[2:0])};
                        if (step.idx == CNT_W'(PREFIX_LEN - 1)) begin
                            phase_next = flags_next[1] ? PH_SIGN : PH_DONE;
                            field_next = 2'd0;
                        end
                    end
                end
                PH_SIGN: begin
                    priority if (is_space(step.ch)) begin
                        phase_next = PH_SIGN;
                    end else if (step.ch == CH_PLUS || step.ch == CH_MINUS) begin
                        sign_next  = (step.ch == CH_MINUS);
                        phase_next = PH_FIRST;
                    end else begin
                        sign_next  = 1'b0;
                        take_first = 1'b1;
                    end
                end
                PH_FIRST: begin
                    take_first = 1'b1;
                end
                PH_MORE: begin
                    priority if (is_digit(step.ch)) begin
                        do_digit = 1'b1;
                    end else if (step.ch == CH_COMMA && field_reg != 2'd2) begin
                        phase_next = PH_SIGN;
                        field_next = field_reg + 2'd1;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
            // First digit of a field, or end of parsing
            if (take_first) begin
                if (is_digit(step.ch)) begin
                    do_digit     = 1'b1;
                    first_digit  = 1'b1;
                    matched_next = field_reg + 2'd1;
                    phase_next   = PH_MORE;
                end else begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Accumulate one decimal digit into the current field
    always_comb begin
        unique case (field_reg)
            2'd0:    old_val = {8'd0, count_reg};
            2'd1:    old_val = temp_reg;
            default: old_val = dist_reg;
        endcase
        base_val = first_digit ? 16'd0 : ((old_val << 3) + (old_val << 1));
        new_val  = sign_next ? (base_val - digit_val) : (base_val + digit_val);
        count_next = count_reg;
        temp_next  = temp_reg;
        dist_next  = dist_reg;
        if (step.clear) begin
            count_next = 8'd0;
            temp_next  = 16'd0;
            dist_next  = 16'd0;
        end else if (do_digit) begin
            unique case (field_reg)
                2'd0:    count_next = new_val[7:0];
                2'd1:    temp_next  = new_val;
                default: dist_next  = new_val;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PREFIX;
            field_reg   <= 2'd0;
            flags_reg   <= 2'b11;
            sign_reg    <= 1'b0;
            matched_reg <= 2'd0;
            count_reg   <= 8'd0;
            temp_reg    <= 16'd0;
            dist_reg    <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            field_reg   <= field_next;
            flags_reg   <= flags_next;
            sign_reg    <= sign_next;
            matched_reg <= matched_next;
            count_reg   <= count_next;
            temp_reg    <= temp_next;
            dist_reg    <= dist_next;
        end
    end

    assign status.sug_match      = flags_reg[0];
    assign status.fields_matched = matched_reg;
    assign status.count          = count_reg;
    assign status.temp           = temp_reg;
    assign status.dist_val       = dist_reg;

endmodule

// File: design/checksummed_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// checksummed_sentence_parser_core
// Line framer, XOR checksum check and report parser for received bytes.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer and the block sustains one byte per
// clock while results are taken as they come. A byte waits in the input
// register until the result slot is free, then the frame tracker and field
// parser update in a single pass; an LF ending a nonempty frame loads the
// result register as the LF leaves the input register, and that raises m_valid.
// The result register holds the frame kind and the stored report. While a
// result waits with m_ready low no byte is processed, so the input register
// holds its byte and s_ready drops until the result is taken. No reset sweep
// is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module checksummed_sentence_parser_core
    import csp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_line_error,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_frame_kind,
    output logic               m_had_checksum,
    output logic               m_remote_valid,
    output logic [7:0]         m_active_count,
    output logic signed [15:0] m_temp_deci,
    output logic signed [15:0] m_dist_deci,
    output logic               m_temp_valid,
    output logic               m_dist_valid
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_err_reg;
    logic          m_valid_reg, m_valid_next;
    frame_kind_t   kind_reg, kind_next;
    logic          had_cksum_reg;
    logic          stored_valid_reg, stored_valid_next;
    logic [7:0]    stored_count_reg, stored_count_next;
    logic [15:0]   stored_temp_reg, stored_temp_next;
    logic [15:0]   stored_dist_reg, stored_dist_next;
    logic          slot_free;
    logic          proc_fire;
    logic          res_load;
    step_t         step;
    frm_status_t   frm_st;
    parse_status_t prs_st;

    // Process the held byte when the result slot can take a result
    assign slot_free = !m_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && slot_free;
    assign s_ready   = !in_valid_reg || proc_fire;

    // Hold the input transfer
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_err_reg  <= s_line_error;
        end
    end

    // Decode the byte into a frame step
    always_comb begin
        step.ch      = in_byte_reg;
        step.idx     = frm_st.idx;
        step.clear   = 1'b0;
        step.advance = 1'b0;
        res_load     = 1'b0;
        if (proc_fire) begin
            priority if (in_err_reg) begin
                step.clear = 1'b1;
            end else if (in_byte_reg == CH_CR) begin
                step.clear = 1'b0;
            end else if (in_byte_reg == CH_LF) begin
                step.clear = 1'b1;
                res_load   = !frm_st.empty;
            end else if (frm_st.overfull) begin
                step.clear = 1'b1;
            end else begin
                step.advance = 1'b1;
            end
        end
    end

    csp_frame_track u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .status  (frm_st)
    );

    csp_field_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .status  (prs_st)
    );

    // Classify the frame and update the stored report
    always_comb begin
        stored_valid_next = stored_valid_reg;
        stored_count_next = stored_count_reg;
        stored_temp_next  = stored_temp_reg;
        stored_dist_next  = stored_dist_reg;
        priority if (!frm_st.cksum_ok) begin
            kind_next = KIND_CKSUM_ERR;
        end else if (frm_st.long_enough && prs_st.sug_match) begin
            kind_next = KIND_SUGGEST;
        end else if (prs_st.fields_matched == 2'd3) begin
            kind_next = KIND_FULL;
            if (res_load) begin
                stored_valid_next = 1'b1;
                stored_count_next = prs_st.count;
                stored_temp_next  = prs_st.temp;
                stored_dist_next  = prs_st.dist_val;
            end
        end else if (prs_st.fields_matched != 2'd0) begin
            kind_next = KIND_COUNT;
            if (res_load) begin
                stored_valid_next = 1'b1;
                stored_count_next = prs_st.count;
                stored_temp_next  = '1;
                stored_dist_next  = '1;
            end
        end else begin
            kind_next = KIND_IGNORED;
        end
    end

    // Drop the result on a transfer, load a new one on a frame end
    assign m_valid_next = res_load ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            stored_valid_reg <= 1'b0;
            stored_count_reg <= 8'd0;
            stored_temp_reg  <= '1;
            stored_dist_reg  <= '1;
        end else begin
            m_valid_reg      <= m_valid_next;
            stored_valid_reg <= stored_valid_next;
            stored_count_reg <= stored_count_next;
            stored_temp_reg  <= stored_temp_next;
            stored_dist_reg  <= stored_dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            kind_reg      <= kind_next;
            had_cksum_reg <= frm_st.star_seen;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_kind   = kind_reg;
    assign m_had_checksum = had_cksum_reg;
    assign m_remote_valid = stored_valid_reg;
    assign m_active_count = stored_count_reg;
    assign m_temp_deci    = stored_temp_reg;
    assign m_dist_deci    = stored_dist_reg;
    assign m_temp_valid   = !stored_temp_reg[15];
    assign m_dist_valid   = !stored_dist_reg[15];

    // Assertions
    `ASSERT_CLK(a_no_load_on_stall, (m_valid_reg && !m_ready) |-> !res_load)
    `ASSERT_CLK(a_remote_valid_sticky, !$fell(stored_valid_reg))
    `ASSERT_CLK(a_count_only_clears, (res_load && kind_next == KIND_COUNT) |=> (stored_temp_reg == 16'hFFFF && stored_dist_reg == 16'hFFFF))
    `ASSERT_CLK(a_cksum_err_keeps, (res_load && kind_next == KIND_CKSUM_ERR) |=> ($stable(stored_count_reg) && $stable(stored_temp_reg) && $stable(stored_dist_reg)))
    `ASSERT_ALWAYS(a_reset_idle, (!aresetn) |=> (!m_valid && !in_valid_reg))

endmodule

// File: verif/tb_checksummed_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// tb_checksummed_sentence_parser_core
// Self-checking bench for the sentence parser core. Directed frames cover
// each frame class, the checksum trailer forms, line errors, the frame
// length limit and number wrap. Random frames cover the rest. A local
// byte-level model predicts each result, and a monitor checks every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checksummed_sentence_parser_core;
    import csp_pkg::*;

    localparam int          RANDOM_ITEMS = 1030;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam logic [39:0] SUG_TAG      = {8'h24, 8'h53, 8'h55, 8'h47, 8'h2C};
    localparam logic [39:0] REP_TAG      = {8'h24, 8'h45, 8'h53, 8'h50, 8'h2C};

    // Parser phases: 0 is the prefix, 1..9 are three steps per field
    localparam logic [3:0] PHASE_PREFIX = 4'd0;
    localparam logic [3:0] PHASE_STOP   = 4'd10;
    localparam int         SUB_SIGN     = 0;
    localparam int         SUB_FIRST    = 1;

    typedef enum int {
        TR_NONE, TR_GOOD, TR_WRONG, TR_SHORT, TR_LONG, TR_NOT_HEX
    } trailer_style_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        had_ck;
        logic        rem_valid;
        logic [7:0]  count;
        logic [15:0] temp;
        logic [15:0] dist_val;
        logic        temp_ok;
        logic        dist_ok;
    } frame_report_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = 8'h00;
    logic              s_line_error = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_frame_kind;
    logic              m_had_checksum;
    logic              m_remote_valid;
    logic [7:0]        m_active_count;
    logic signed [15:0] m_temp_deci;
    logic signed [15:0] m_dist_deci;
    logic              m_temp_valid;
    logic              m_dist_valid;

    // Bench control
    frame_report_t pending_reports[$];
    logic [7:0]    frame_q[$];
    int            fail_count = 0;
    int            items_sent = 0;
    int            hold_left  = 0;
    bit            idle_on    = 1'b0;
    frame_report_t got_report;
    frame_report_t want_report;

    // Model state: current frame
    logic [6:0]  fb_count;
    logic [7:0]  fb_xor;
    logic [7:0]  fb_xor_at_star;
    logic        fb_star;
    logic [1:0]  fb_after_star;
    logic [7:0]  fb_trailer;
    logic        fb_trailer_bad;
    logic [1:0]  fb_prefix_ok;
    logic [3:0]  fb_phase;
    logic        fb_neg;
    logic [1:0]  fb_fields;
    logic [7:0]  acc_count;
    logic [15:0] acc_temp;
    logic [15:0] acc_dist;

    // Model state: last accepted report
    logic        rep_valid;
    logic [7:0]  rep_count;
    logic [15:0] rep_temp;
    logic [15:0] rep_dist;

    checksummed_sentence_parser_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_line_error   (s_line_error),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_had_checksum (m_had_checksum),
        .m_remote_valid (m_remote_valid),
        .m_active_count (m_active_count),
        .m_temp_deci    (m_temp_deci),
        .m_dist_deci    (m_dist_deci),
        .m_temp_valid   (m_temp_valid),
        .m_dist_valid   (m_dist_valid)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------
    task automatic clear_frame();
        fb_count       = '0;
        fb_xor         = '0;
        fb_xor_at_star = '0;
        fb_star        = 1'b0;
        fb_after_star  = '0;
        fb_trailer     = '0;
        fb_trailer_bad = 1'b0;
        fb_prefix_ok   = 2'b11;
        fb_phase       = PHASE_PREFIX;
        fb_neg         = 1'b0;
        fb_fields      = '0;
        acc_count      = '0;
        acc_temp       = '0;
        acc_dist       = '0;
    endtask

    // Fold one decimal digit into the field accumulator, wrapping at its width
    task automatic accumulate(input int fld, input logic [3:0] d, input bit first);
        logic [15:0] prev;
        logic [15:0] v;
        prev = (fld == 0) ? {8'h00, acc_count} : (fld == 1) ? acc_temp : acc_dist;
        v    = first ? 16'd0 : 16'(prev * 16'd10);
        v    = fb_neg ? 16'(v - {12'd0, d}) : 16'(v + {12'd0, d});
        case (fld)
            0:       acc_count = v[7:0];
            1:       acc_temp  = v;
            default: acc_dist  = v;
        endcase
    endtask

    // Advance the model by one accepted byte; queue a report on a frame end
    task automatic track_byte(input logic [7:0] c, input logic err);
        frame_report_t r;
        logic [4:0]    nib;
        logic [6:0]    idx;
        logic          ok;
        logic          is_dig;
        int            fld;
        int            sub;

        if (err) begin
            clear_frame();
            return;
        end
        if (c == CH_CR) return;

        // Close the frame on LF
        if (c == CH_LF) begin
            if (fb_count == 0) begin
                clear_frame();
                return;
            end
            ok = !fb_star || (fb_after_star == 2'd2 && !fb_trailer_bad &&
                              fb_trailer == fb_xor_at_star);
            if (!ok) begin
                r.kind = KIND_CKSUM_ERR;
            end else if (fb_count >= 7'(PREFIX_LEN) && fb_prefix_ok[0]) begin
                r.kind = KIND_SUGGEST;
            end else if (fb_fields == 2'd3) begin
                r.kind    = KIND_FULL;
                rep_count = acc_count;
                rep_temp  = acc_temp;
                rep_dist  = acc_dist;
                rep_valid = 1'b1;
            end else if (fb_fields != 2'd0) begin
                r.kind    = KIND_COUNT;
                rep_count = acc_count;
                rep_temp  = 16'hFFFF;
                rep_dist  = 16'hFFFF;
                rep_valid = 1'b1;
            end else begin
                r.kind = KIND_IGNORED;
            end
            r.had_ck    = fb_star;
            r.rem_valid = rep_valid;
            r.count     = rep_count;
            r.temp      = rep_temp;
            r.dist_val  = rep_dist;
            r.temp_ok   = ~rep_temp[15];
            r.dist_ok   = ~rep_dist[15];
            pending_reports.push_back(r);
            clear_frame();
            return;
        end

        // Drop the byte and the frame once the buffer is full
        if (fb_count >= 7'(FRAME_BYTES - 1)) begin
            clear_frame();
            return;
        end

        // Track the checksum trailer after the last star
        if (c == CH_STAR) begin
            fb_xor_at_star = fb_xor;
            fb_star        = 1'b1;
            fb_after_star  = '0;
            fb_trailer     = '0;
            fb_trailer_bad = 1'b0;
        end else if (fb_star) begin
            if (c >= CH_ZERO && c <= CH_NINE)                  nib = {1'b1, c[3:0]};
            else if ((c >= 8'h41 && c <= 8'h46) ||
                     (c >= 8'h61 && c <= 8'h66))               nib = {1'b1, 4'(c[3:0] + 4'd9)};
            else                                               nib = 5'd0;
            if (fb_after_star != 2'd3) fb_after_star = fb_after_star + 2'd1;
            if (!nib[4]) fb_trailer_bad = 1'b1;
            else         fb_trailer     = {fb_trailer[3:0], nib[3:0]};
        end
        if (!(fb_count == 0 && c == CH_DOLLAR)) fb_xor = fb_xor ^ c;

        idx      = fb_count;
        fb_count = fb_count + 7'd1;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);

        // Match the two prefixes
        if (fb_phase == PHASE_PREFIX) begin
            if (idx < 7'(PREFIX_LEN)) begin
                if (c != SUG_TAG[39 - 8 * idx -: 8]) fb_prefix_ok[0] = 1'b0;
                if (c != REP_TAG[39 - 8 * idx -: 8]) fb_prefix_ok[1] = 1'b0;
                if (idx == 7'(PREFIX_LEN - 1)) begin
                    fb_phase = fb_prefix_ok[1] ? 4'd1 : PHASE_STOP;
                end
            end
            return;
        end
        if (fb_phase >= PHASE_STOP) return;

        // Parse count, temperature and distance
        fld = (int'(fb_phase) - 1) / 3;
        sub = (int'(fb_phase) - 1) % 3;
        if (sub == SUB_SIGN) begin
            if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                fb_neg   = (c == CH_MINUS);
                fb_phase = fb_phase + 4'd1;
                return;
            end
            fb_neg = 1'b0;
            sub    = SUB_FIRST;
        end
        if (sub == SUB_FIRST) begin
            if (is_dig) begin
                accumulate(fld, c[3:0], 1'b1);
                fb_fields = 2'(fld + 1);
                fb_phase  = 4'(3 * fld + 3);
            end else begin
                fb_phase = PHASE_STOP;
            end
            return;
        end
        if (is_dig)                         accumulate(fld, c[3:0], 1'b0);
        else if (c == CH_COMMA && fld < 2)  fb_phase = 4'(3 * fld + 4);
        else                                fb_phase = PHASE_STOP;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one byte and hold it until the transfer; enter and leave at negedge
    task automatic send_item(input logic [7:0] c, input logic err);
        if (idle_on && $urandom_range(99) < 13) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_rx_byte    = c;
        s_line_error = err;
        do @(posedge aclk); while (s_ready !== 1'b1);
        track_byte(c, err);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Send the built frame with an LF; optionally a line error before byte err_pos
    task automatic send_frame(input int err_pos);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (i == err_pos) send_item(8'($urandom_range(255)), 1'b1);
            if ($urandom_range(99) < 2) send_item(CH_CR, 1'b0);
            send_item(frame_q[i], 1'b0);
        end
        if (err_pos >= frame_q.size()) send_item(8'($urandom_range(255)), 1'b1);
        send_item(CH_LF, 1'b0);
        frame_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------
    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    task automatic put_tag(input logic [39:0] tag, input int n);
        for (int i = 0; i < n; i++) frame_q.push_back(tag[39 - 8 * i -: 8]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Random number: optional blank, optional sign, up to max_digits digits
    task automatic put_number(input int max_digits);
        int n;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0:       frame_q.push_back(CH_SPACE);
                1:       frame_q.push_back(8'h09);
                2:       frame_q.push_back(8'h0B);
                default: frame_q.push_back(8'h0C);
            endcase
        end
        case ($urandom_range(3))
            0:       frame_q.push_back(CH_PLUS);
            1:       frame_q.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, max_digits);
        repeat (n) frame_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // Append a star trailer computed over the frame so far
    task automatic put_trailer(input trailer_style_t style);
        logic [7:0] x;
        bit         up;
        string      junk;
        x    = 8'h00;
        up   = $urandom_range(1);
        junk = "GgZz!-/:";
        if (style == TR_NONE) return;
        for (int i = 0; i < frame_q.size(); i++) begin
            if (!(i == 0 && frame_q[i] == CH_DOLLAR)) x = x ^ frame_q[i];
        end
        if (style == TR_WRONG) x = x ^ (8'h01 << $urandom_range(7));
        frame_q.push_back(CH_STAR);
        frame_q.push_back(hex_char(x[7:4], up));
        case (style)
            TR_SHORT:   ;
            TR_NOT_HEX: frame_q.push_back(junk[$urandom_range(junk.len() - 1)]);
            TR_LONG: begin
                frame_q.push_back(hex_char(x[3:0], up));
                frame_q.push_back(hex_char(4'($urandom_range(15)), up));
            end
            default:    frame_q.push_back(hex_char(x[3:0], up));
        endcase
    endtask

    function automatic trailer_style_t pick_trailer();
        int p;
        p = $urandom_range(99);
        if (p < 30) return TR_NONE;
        if (p < 75) return TR_GOOD;
        if (p < 85) return TR_WRONG;
        if (p < 90) return TR_SHORT;
        if (p < 95) return TR_LONG;
        return TR_NOT_HEX;
    endfunction

    // Report with 0 to 3 fields and random content
    task automatic build_report();
        int p;
        int nf;
        p  = $urandom_range(99);
        nf = (p < 60) ? 3 : (p < 75) ? 1 : (p < 90) ? 2 : 0;
        put_tag(REP_TAG, PREFIX_LEN);
        for (int i = 0; i < nf; i++) begin
            if (i > 0) frame_q.push_back(CH_COMMA);
            put_number((i == 0) ? 4 : 6);
        end
        if ($urandom_range(99) < 10) frame_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        put_trailer(pick_trailer());
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    // Drop ready during a requested hold-off, else at random when idling is on
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else if (idle_on && $urandom_range(99) < 13) begin
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            got_report = '{m_frame_kind, m_had_checksum, m_remote_valid, m_active_count,
                           m_temp_deci, m_dist_deci, m_temp_valid, m_dist_valid};
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result: kind %0d", m_frame_kind);
            end else begin
                want_report = pending_reports.pop_front();
                if (got_report !== want_report) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: exp kind %0d ck %0d rv %0d cnt %0d t %0d d %0d tv %0d dv %0d",
                                 want_report.kind, want_report.had_ck, want_report.rem_valid,
                                 want_report.count, $signed(want_report.temp),
                                 $signed(want_report.dist_val), want_report.temp_ok,
                                 want_report.dist_ok);
                        $display("          got kind %0d ck %0d rv %0d cnt %0d t %0d d %0d tv %0d dv %0d",
                                 got_report.kind, got_report.had_ck, got_report.rem_valid,
                                 got_report.count, $signed(got_report.temp),
                                 $signed(got_report.dist_val), got_report.temp_ok,
                                 got_report.dist_ok);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty lines, lone CR and a zero byte frame
    task automatic test_empty_lines();
        send_item(CH_LF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        frame_q.push_back(8'h00);
        send_frame(-1);
    endtask

    // One suggestion, full report, count-only report and ignored frame
    task automatic test_frame_classes();
        put_tag(SUG_TAG, PREFIX_LEN);
        put_text("go");
        send_frame(-1);
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("3,-12,+45");
        put_trailer(TR_GOOD);
        send_frame(-1);
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("7");
        send_frame(-1);
        put_text("hi");
        send_frame(-1);
    endtask

    // Bad trailers: wrong value, one digit, three digits, not hex
    task automatic test_checksum_errors();
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("1,2,3");
        put_trailer(TR_WRONG);
        send_frame(-1);
        put_text("$a");
        put_trailer(TR_SHORT);
        send_frame(-1);
        put_text("b");
        put_trailer(TR_LONG);
        send_frame(-1);
        put_text("c*");
        put_trailer(TR_NOT_HEX);
        send_frame(-1);
    endtask

    // Line error drops the partial frame
    task automatic test_line_error();
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("9,1,1");
        send_frame(3);
        put_text("x");
        send_frame(1);
    endtask

    // Longest frame kept, then one byte too many
    task automatic test_frame_limit();
        repeat (FRAME_BYTES - 1) frame_q.push_back(8'h41);
        send_frame(-1);
        repeat (FRAME_BYTES) frame_q.push_back(8'h42);
        send_frame(-1);
    endtask

    // Field extremes, wrap, blanks and signs
    task automatic test_number_extremes();
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("255,-32768,32767");
        send_frame(-1);
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("\t256, 65535,-0");
        put_trailer(TR_GOOD);
        send_frame(-1);
        put_tag(REP_TAG, PREFIX_LEN);
        put_text("+,5");
        send_frame(-1);
    endtask

    // Random frames: mostly well formed, plus noise and broken frames
    task automatic test_random_frames();
        int start;
        int sel;
        int err_pos;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            idle_on = (items_sent - start) > 250;
            sel     = $urandom_range(99);
            err_pos = -1;
            if (sel < 50) begin
                build_report();
            end else if (sel < 62) begin
                put_tag(SUG_TAG, PREFIX_LEN);
                repeat ($urandom_range(10)) frame_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                put_trailer(pick_trailer());
            end else if (sel < 74) begin
                repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(255)));
            end else if (sel < 86) begin
                build_report();
                frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
            end else if (sel < 92) begin
                build_report();
                err_pos = $urandom_range(frame_q.size());
            end else if (sel < 97) begin
                put_tag(($urandom_range(1) != 0) ? REP_TAG : SUG_TAG, $urandom_range(1, 4));
            end else begin
                repeat ($urandom_range(FRAME_BYTES - 8, FRAME_BYTES + 4)) begin
                    frame_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
            send_frame(err_pos);
        end
    endtask

    // Receiver holds off while short frames keep coming, so the input stalls
    task automatic test_backpressure();
        @(posedge aclk);
        hold_left = 400;
        @(negedge aclk);
        repeat (40) begin
            frame_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            send_frame(-1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_frame();
        rep_valid = 1'b0;
        rep_count = '0;
        rep_temp  = 16'hFFFF;
        rep_dist  = 16'hFFFF;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_lines();
        test_frame_classes();
        test_checksum_errors();
        test_line_error();
        test_frame_limit();
        test_number_extremes();
        test_random_frames();
        test_backpressure();

        // Drain outstanding results
        s_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_checksummed_sentence_parser_core: done, clean");
        end else begin
            $display("tb_checksummed_sentence_parser_core: done, errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_checksummed_sentence_parser_core: done, errors");
        $finish;
    end

endmodule

// File: checksummed_sentence_parser_core.f
+incdir+design
design/csp_pkg.sv
design/csp_frame_track.sv
design/csp_field_parse.sv
design/checksummed_sentence_parser_core.sv
verif/tb_checksummed_sentence_parser_core.sv
